>>> rtl/rhc_pkg.sv
// Shared widths and types for the RGB to HSL converter.
package rhc_pkg;

  localparam int HUE_W   = 15;
  localparam int SAT_W   = 12;
  localparam int LIGHT_W = 9;
  localparam int DIV_Q_W = 15;
  localparam int SAT_MAX = 4095;

  typedef struct packed {
    logic [LIGHT_W-1:0] lightness;
    logic               gray;
  } side_t;

endpackage

>>> rtl/rhc_if.sv
// Valid/ready channel interfaces for RGB input items and HSL result items.
interface rhc_rgb_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsl_if;
  logic                        valid;
  logic                        ready;
  logic [rhc_pkg::HUE_W-1:0]   hue_angle;
  logic [rhc_pkg::SAT_W-1:0]   saturation_level;
  logic [rhc_pkg::LIGHT_W-1:0] lightness_twice;
  logic                        is_gray;

  modport source (output valid, output hue_angle, output saturation_level,
                  output lightness_twice, output is_gray, input ready);
  modport sink   (input valid, input hue_angle, input saturation_level,
                  input lightness_twice, input is_gray, output ready);
endinterface

>>> rtl/rhc_front.sv
// Front stages: min/max and hue sector, then sums, denominators and dividends.
module rhc_front #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     up_valid,
  output logic                                     up_ready,
  input  logic [CHANNEL_BITS-1:0]                  red,
  input  logic [CHANNEL_BITS-1:0]                  green,
  input  logic [CHANNEL_BITS-1:0]                  blue,
  output logic                                     down_valid,
  input  logic                                     down_ready,
  output logic [CHANNEL_BITS+rhc_pkg::DIV_Q_W-1:0] hue_num,
  output logic [CHANNEL_BITS+rhc_pkg::DIV_Q_W-1:0] sat_num,
  output logic [CHANNEL_BITS-1:0]                  hue_den,
  output logic [CHANNEL_BITS-1:0]                  sat_den,
  output rhc_pkg::side_t                           side
);

  localparam int CB    = CHANNEL_BITS;
  localparam int NUM_W = CB + 3;
  localparam int DIV_W = CB + rhc_pkg::DIV_Q_W;
  localparam logic [CB:0] FULL     = {1'b0, {CB{1'b1}}};
  localparam logic [CB:0] FULL_X2  = {{CB{1'b1}}, 1'b0};

  typedef enum logic [1:0] {SEC_RED, SEC_GREEN, SEC_BLUE} sector_t;

  // stage A
  logic          va_r;
  logic [CB-1:0] r_r, g_r, b_r, lo_r, hi_r;
  sector_t       sec_r;
  logic [CB-1:0] lo_nxt, hi_nxt, lo_rg, hi_rg;
  sector_t       sec_nxt;
  logic          en_a, en_b;

  always_comb begin
    lo_rg = (red < green) ? red : green;
    hi_rg = (red < green) ? green : red;
    lo_nxt = lo_rg;
    hi_nxt = hi_rg;
    if (blue < lo_rg) begin
      lo_nxt = blue;
    end else if (blue > hi_rg) begin
      hi_nxt = blue;
    end
    if (hi_nxt == red) begin
      sec_nxt = SEC_RED;
    end else if (hi_nxt == green) begin
      sec_nxt = SEC_GREEN;
    end else begin
      sec_nxt = SEC_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en_a) begin
      va_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      r_r   <= red;
      g_r   <= green;
      b_r   <= blue;
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      sec_r <= sec_nxt;
    end
  end

  // stage B
  logic             vb_r;
  logic [DIV_W-1:0] hue_num_r, sat_num_r;
  logic [CB-1:0]    delta_r, den_r;
  rhc_pkg::side_t   side_r;

  logic [CB-1:0]    delta;
  logic [CB:0]      sum, den_full;
  logic [NUM_W-1:0] d_ext, num;
  logic [DIV_W-1:0] num_ext, hue_num_nxt, sat_num_nxt;

  always_comb begin
    delta    = hi_r - lo_r;
    sum      = {1'b0, lo_r} + {1'b0, hi_r};
    den_full = (sum <= FULL) ? sum : (FULL_X2 - sum);
    d_ext    = NUM_W'(delta);
    case (sec_r)
      SEC_RED: begin
        if (g_r >= b_r) begin
          num = NUM_W'(g_r) - NUM_W'(b_r);
        end else begin
          num = (d_ext << 2) + (d_ext << 1) - (NUM_W'(b_r) - NUM_W'(g_r));
        end
      end
      SEC_GREEN: num = (d_ext << 1) + NUM_W'(b_r) - NUM_W'(r_r);
      SEC_BLUE:  num = (d_ext << 2) + NUM_W'(r_r) - NUM_W'(g_r);
      default:   num = '0;
    endcase
    num_ext     = DIV_W'(num);
    hue_num_nxt = (num_ext << 12) - (num_ext << 8);
    sat_num_nxt = DIV_W'(delta) << 12;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en_b) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      hue_num_r        <= hue_num_nxt;
      sat_num_r        <= sat_num_nxt;
      delta_r          <= delta;
      den_r            <= den_full[CB-1:0];
      side_r.lightness <= rhc_pkg::LIGHT_W'(sum);
      side_r.gray      <= (lo_r == hi_r);
    end
  end

  assign en_b       = !vb_r || down_ready;
  assign en_a       = !va_r || en_b;
  assign up_ready   = en_a;
  assign down_valid = vb_r;
  assign hue_num    = hue_num_r;
  assign sat_num    = sat_num_r;
  assign hue_den    = delta_r;
  assign sat_den    = den_r;
  assign side       = side_r;

endmodule

>>> rtl/rhc_div_pipe.sv
// Pipelined restoring dividers for hue and saturation, one quotient bit per stage.
module rhc_div_pipe #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     up_valid,
  output logic                                     up_ready,
  input  logic [CHANNEL_BITS+rhc_pkg::DIV_Q_W-1:0] hue_num,
  input  logic [CHANNEL_BITS+rhc_pkg::DIV_Q_W-1:0] sat_num,
  input  logic [CHANNEL_BITS-1:0]                  hue_den,
  input  logic [CHANNEL_BITS-1:0]                  sat_den,
  input  rhc_pkg::side_t                           side_in,
  output logic                                     down_valid,
  input  logic                                     down_ready,
  output logic [rhc_pkg::DIV_Q_W-1:0]              hue_quo,
  output logic [rhc_pkg::DIV_Q_W-1:0]              sat_quo,
  output rhc_pkg::side_t                           side_out
);

  localparam int CB = CHANNEL_BITS;
  localparam int Q  = rhc_pkg::DIV_Q_W;

  // quotient below 2^Q, so the top bits of the dividend start below the divisor
  logic [Q-1:0]   vld_r;
  logic [CB-1:0]  hrem_r [0:Q-1];
  logic [CB-1:0]  srem_r [0:Q-1];
  logic [Q-1:0]   hlow_r [0:Q-1];
  logic [Q-1:0]   slow_r [0:Q-1];
  logic [CB-1:0]  hden_r [0:Q-1];
  logic [CB-1:0]  sden_r [0:Q-1];
  rhc_pkg::side_t side_r [0:Q-1];
  logic [Q:0]     en;

  assign en[Q] = down_ready;

  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic           p_vld;
    logic [CB-1:0]  p_hrem, p_srem, p_hden, p_sden;
    logic [Q-1:0]   p_hlow, p_slow;
    rhc_pkg::side_t p_side;
    logic [CB:0]    h_trial, s_trial, h_diff, s_diff;
    logic           h_ge, s_ge;

    if (k == 0) begin : g_head
      assign p_vld  = up_valid;
      assign p_hrem = hue_num[CB+Q-1:Q];
      assign p_hlow = hue_num[Q-1:0];
      assign p_srem = sat_num[CB+Q-1:Q];
      assign p_slow = sat_num[Q-1:0];
      assign p_hden = hue_den;
      assign p_sden = sat_den;
      assign p_side = side_in;
    end else begin : g_body
      assign p_vld  = vld_r[k-1];
      assign p_hrem = hrem_r[k-1];
      assign p_hlow = hlow_r[k-1];
      assign p_srem = srem_r[k-1];
      assign p_slow = slow_r[k-1];
      assign p_hden = hden_r[k-1];
      assign p_sden = sden_r[k-1];
      assign p_side = side_r[k-1];
    end

    always_comb begin
      h_trial = {p_hrem, p_hlow[Q-1]};
      s_trial = {p_srem, p_slow[Q-1]};
      h_ge    = (h_trial >= {1'b0, p_hden});
      s_ge    = (s_trial >= {1'b0, p_sden});
      h_diff  = h_trial - {1'b0, p_hden};
      s_diff  = s_trial - {1'b0, p_sden};
    end

    assign en[k] = !vld_r[k] || en[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en[k]) begin
        vld_r[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        hrem_r[k] <= h_ge ? h_diff[CB-1:0] : h_trial[CB-1:0];
        srem_r[k] <= s_ge ? s_diff[CB-1:0] : s_trial[CB-1:0];
        hlow_r[k] <= {p_hlow[Q-2:0], h_ge};
        slow_r[k] <= {p_slow[Q-2:0], s_ge};
        hden_r[k] <= p_hden;
        sden_r[k] <= p_sden;
        side_r[k] <= p_side;
      end
    end
  end

  assign up_ready   = en[0];
  assign down_valid = vld_r[Q-1];
  assign hue_quo    = hlow_r[Q-1];
  assign sat_quo    = slow_r[Q-1];
  assign side_out   = side_r[Q-1];

endmodule

>>> rtl/rhc_finish.sv
// Output stage: gray override, saturation clamp and the result register.
module rhc_finish (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [rhc_pkg::DIV_Q_W-1:0] hue_quo,
  input  logic [rhc_pkg::DIV_Q_W-1:0] sat_quo,
  input  rhc_pkg::side_t              side,
  output logic                        down_valid,
  input  logic                        down_ready,
  output logic [rhc_pkg::HUE_W-1:0]   hue_angle,
  output logic [rhc_pkg::SAT_W-1:0]   saturation_level,
  output logic [rhc_pkg::LIGHT_W-1:0] lightness_twice,
  output logic                        is_gray
);

  logic                        v_r;
  logic [rhc_pkg::HUE_W-1:0]   hue_r, hue_nxt;
  logic [rhc_pkg::SAT_W-1:0]   sat_r, sat_nxt;
  logic [rhc_pkg::LIGHT_W-1:0] light_r;
  logic                        gray_r;
  logic                        en;

  always_comb begin
    if (side.gray) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end else begin
      hue_nxt = rhc_pkg::HUE_W'(hue_quo);
      if (sat_quo > rhc_pkg::DIV_Q_W'(rhc_pkg::SAT_MAX)) begin
        sat_nxt = rhc_pkg::SAT_W'(rhc_pkg::SAT_MAX);
      end else begin
        sat_nxt = sat_quo[rhc_pkg::SAT_W-1:0];
      end
    end
  end

  assign en = !v_r || down_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
      light_r <= side.lightness;
      gray_r  <= side.gray;
    end
  end

  assign up_ready         = en;
  assign down_valid       = v_r;
  assign hue_angle        = hue_r;
  assign saturation_level = sat_r;
  assign lightness_twice  = light_r;
  assign is_gray          = gray_r;

endmodule

>>> rtl/rgb_to_hsl_convert_unit.sv
// RGB to HSL converter, top level.
// Takes one RGB pixel per clock and returns hue in 1/64 degree, saturation
// scaled by 4096 (clamped to 4095), min+max as twice the lightness, and a gray
// flag. It has two front stages (min/max, then sums and dividends), fifteen
// divider stages that each resolve one quotient bit of both the hue and the
// saturation divide, and one output register. Every stage holds its own
// valid bit and fills bubbles while the output stalls, so the block takes a
// new pixel each cycle unless the output stalls and all stages hold items.
module rgb_to_hsl_convert_unit #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  rhc_rgb_if.sink      in_pix,
  rhc_hsl_if.source    out_hsl
);

  localparam int DIV_W = CHANNEL_BITS + rhc_pkg::DIV_Q_W;

  logic                        f_valid, f_ready;
  logic [DIV_W-1:0]            f_hue_num, f_sat_num;
  logic [CHANNEL_BITS-1:0]     f_hue_den, f_sat_den;
  rhc_pkg::side_t              f_side;

  logic                        d_valid, d_ready;
  logic [rhc_pkg::DIV_Q_W-1:0] d_hue_quo, d_sat_quo;
  rhc_pkg::side_t              d_side;

  rhc_front #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_pix.valid),
    .up_ready   (in_pix.ready),
    .red        (in_pix.red),
    .green      (in_pix.green),
    .blue       (in_pix.blue),
    .down_valid (f_valid),
    .down_ready (f_ready),
    .hue_num    (f_hue_num),
    .sat_num    (f_sat_num),
    .hue_den    (f_hue_den),
    .sat_den    (f_sat_den),
    .side       (f_side)
  );

  rhc_div_pipe #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (f_valid),
    .up_ready   (f_ready),
    .hue_num    (f_hue_num),
    .sat_num    (f_sat_num),
    .hue_den    (f_hue_den),
    .sat_den    (f_sat_den),
    .side_in    (f_side),
    .down_valid (d_valid),
    .down_ready (d_ready),
    .hue_quo    (d_hue_quo),
    .sat_quo    (d_sat_quo),
    .side_out   (d_side)
  );

  rhc_finish u_finish (
    .clk              (clk),
    .rst_n            (rst_n),
    .up_valid         (d_valid),
    .up_ready         (d_ready),
    .hue_quo          (d_hue_quo),
    .sat_quo          (d_sat_quo),
    .side             (d_side),
    .down_valid       (out_hsl.valid),
    .down_ready       (out_hsl.ready),
    .hue_angle        (out_hsl.hue_angle),
    .saturation_level (out_hsl.saturation_level),
    .lightness_twice  (out_hsl.lightness_twice),
    .is_gray          (out_hsl.is_gray)
  );

endmodule
